FILE: src/lodi_pkg.sv
// ----------------------------------------------------------------------------
// lodi_pkg
// shared types, constants and the step microprogram of the integrator
// ----------------------------------------------------------------------------
package lodi_pkg;

  localparam int WORD_W    = 64;
  localparam int FRAC_BITS = 32;
  localparam int PC_W      = 6;

  localparam logic [WORD_W-1:0] MAXV = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [WORD_W-1:0] MINV = {1'b1, {(WORD_W-1){1'b0}}};

  localparam logic [1:0] M_EULER = 2'd0;
  localparam logic [1:0] M_HEUN  = 2'd1;
  localparam logic [1:0] M_RK4   = 2'd2;
  localparam logic [1:0] M_ABM   = 2'd3;

  localparam logic [1:0] REG_METHOD  = 2'd0;
  localparam logic [1:0] REG_RATE    = 2'd1;
  localparam logic [1:0] REG_STEP    = 2'd2;
  localparam logic [1:0] REG_INITIAL = 2'd3;

  typedef enum logic [2:0] {OP_LD, OP_ADD, OP_SUB, OP_MUL, OP_MULC, OP_DIVC} op_t;
  typedef enum logic [2:0] {
    SRC_K, SRC_H, SRC_Y, SRC_G0, SRC_G1, SRC_G2, SRC_TMP, SRC_ACC
  } src_t;

  typedef enum logic [2:0] {S_IDLE, S_FETCH, S_START, S_WAIT, S_DONE} state_t;
  typedef enum logic [1:0] {AL_IDLE, AL_MUL, AL_DIV, AL_FIN} alu_state_t;

  typedef struct packed {
    op_t        op;
    src_t       src;
    logic [1:0] addr;
    logic [5:0] cval;
    logic       st;
    logic       last;
  } uop_t;

  typedef struct packed {
    logic              start;
    op_t               op;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [5:0]        c;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic              sat;
    logic [WORD_W-1:0] result;
  } alu_rsp_t;

  function automatic uop_t mk(op_t op, src_t src, logic [1:0] addr, logic [5:0] cval,
                              logic st, logic last);
    uop_t u;
    u.op = op; u.src = src; u.addr = addr; u.cval = cval; u.st = st; u.last = last;
    return u;
  endfunction

  function automatic uop_t get_uop(logic [1:0] mode, logic [PC_W-1:0] pc);
    uop_t u;
    logic [PC_W-1:0] cp;
    u = mk(OP_LD, SRC_Y, 2'd0, 6'd0, 1'b0, 1'b1);
    cp = (pc >= PC_W'(24)) ? pc - PC_W'(11) : pc;
    if (pc == PC_W'(0)) begin
      u = mk(OP_LD, SRC_K, 2'd0, 6'd0, 1'b0, 1'b0);
    end else if (pc == PC_W'(1)) begin
      u = mk(OP_MUL, SRC_Y, 2'd0, 6'd0, 1'b1, 1'b0);
    end else begin
      case (mode)
        M_EULER: begin
          case (pc)
            6'd2: u = mk(OP_MUL, SRC_H, 2'd0, 6'd0, 1'b0, 1'b0);
            default: u = mk(OP_ADD, SRC_Y, 2'd0, 6'd0, 1'b0, 1'b1);
          endcase
        end
        M_HEUN: begin
          case (pc)
            6'd2: u = mk(OP_MUL, SRC_H, 2'd0, 6'd0, 1'b0, 1'b0);
            6'd3: u = mk(OP_ADD, SRC_Y, 2'd0, 6'd0, 1'b0, 1'b0);
            6'd4: u = mk(OP_MUL, SRC_K, 2'd0, 6'd0, 1'b0, 1'b0);
            6'd5: u = mk(OP_ADD, SRC_TMP, 2'd0, 6'd0, 1'b0, 1'b0);
            6'd6: u = mk(OP_MUL, SRC_H, 2'd0, 6'd0, 1'b0, 1'b0);
            6'd7: u = mk(OP_DIVC, SRC_ACC, 2'd0, 6'd2, 1'b0, 1'b0);
            default: u = mk(OP_ADD, SRC_Y, 2'd0, 6'd0, 1'b0, 1'b1);
          endcase
        end
        M_RK4: begin
          case (pc)
            6'd2:  u = mk(OP_MUL, SRC_H, 2'd0, 6'd0, 1'b0, 1'b0);
            6'd3:  u = mk(OP_DIVC, SRC_ACC, 2'd0, 6'd2, 1'b0, 1'b0);
            6'd4:  u = mk(OP_ADD, SRC_Y, 2'd0, 6'd0, 1'b0, 1'b0);
            6'd5:  u = mk(OP_MUL, SRC_K, 2'd1, 6'd0, 1'b1, 1'b0);
            6'd6:  u = mk(OP_MUL, SRC_H, 2'd0, 6'd0, 1'b0, 1'b0);
            6'd7:  u = mk(OP_DIVC, SRC_ACC, 2'd0, 6'd2, 1'b0, 1'b0);
            6'd8:  u = mk(OP_ADD, SRC_Y, 2'd0, 6'd0, 1'b0, 1'b0);
            6'd9:  u = mk(OP_MUL, SRC_K, 2'd2, 6'd0, 1'b1, 1'b0);
            6'd10: u = mk(OP_MUL, SRC_H, 2'd0, 6'd0, 1'b0, 1'b0);
            6'd11: u = mk(OP_ADD, SRC_Y, 2'd0, 6'd0, 1'b0, 1'b0);
            6'd12: u = mk(OP_MUL, SRC_K, 2'd3, 6'd0, 1'b1, 1'b0);
            6'd13: u = mk(OP_MULC, SRC_TMP, 2'd2, 6'd2, 1'b1, 1'b0);
            6'd14: u = mk(OP_MULC, SRC_TMP, 2'd1, 6'd2, 1'b0, 1'b0);
            6'd15: u = mk(OP_ADD, SRC_TMP, 2'd0, 6'd0, 1'b0, 1'b0);
            6'd16: u = mk(OP_ADD, SRC_TMP, 2'd2, 6'd0, 1'b0, 1'b0);
            6'd17: u = mk(OP_ADD, SRC_TMP, 2'd3, 6'd0, 1'b0, 1'b0);
            6'd18: u = mk(OP_MUL, SRC_H, 2'd0, 6'd0, 1'b0, 1'b0);
            6'd19: u = mk(OP_DIVC, SRC_ACC, 2'd0, 6'd6, 1'b0, 1'b0);
            default: u = mk(OP_ADD, SRC_Y, 2'd0, 6'd0, 1'b0, 1'b1);
          endcase
        end
        default: begin
          case (cp)
            6'd2:  u = mk(OP_MULC, SRC_G0, 2'd1, 6'd59, 1'b1, 1'b0);
            6'd3:  u = mk(OP_MULC, SRC_TMP, 2'd0, 6'd55, 1'b0, 1'b0);
            6'd4:  u = mk(OP_SUB, SRC_TMP, 2'd1, 6'd0, 1'b1, 1'b0);
            6'd5:  u = mk(OP_MULC, SRC_G1, 2'd0, 6'd37, 1'b0, 1'b0);
            6'd6:  u = mk(OP_ADD, SRC_TMP, 2'd1, 6'd0, 1'b1, 1'b0);
            6'd7:  u = mk(OP_MULC, SRC_G2, 2'd2, 6'd9, 1'b1, 1'b0);
            6'd8:  u = mk(OP_LD, SRC_TMP, 2'd1, 6'd0, 1'b0, 1'b0);
            6'd9:  u = mk(OP_SUB, SRC_TMP, 2'd2, 6'd0, 1'b0, 1'b0);
            6'd10: u = mk(OP_MUL, SRC_H, 2'd0, 6'd0, 1'b0, 1'b0);
            6'd11: u = mk(OP_DIVC, SRC_ACC, 2'd0, 6'd24, 1'b0, 1'b0);
            6'd12: u = mk(OP_ADD, SRC_Y, 2'd0, 6'd0, 1'b0, 1'b0);
            6'd13: u = mk(OP_MUL, SRC_K, 2'd0, 6'd0, 1'b0, 1'b0);
            6'd14: u = mk(OP_MULC, SRC_ACC, 2'd1, 6'd9, 1'b1, 1'b0);
            6'd15: u = mk(OP_MULC, SRC_TMP, 2'd0, 6'd19, 1'b0, 1'b0);
            6'd16: u = mk(OP_ADD, SRC_TMP, 2'd1, 6'd0, 1'b1, 1'b0);
            6'd17: u = mk(OP_MULC, SRC_G0, 2'd2, 6'd5, 1'b1, 1'b0);
            6'd18: u = mk(OP_LD, SRC_TMP, 2'd1, 6'd0, 1'b0, 1'b0);
            6'd19: u = mk(OP_SUB, SRC_TMP, 2'd2, 6'd0, 1'b0, 1'b0);
            6'd20: u = mk(OP_ADD, SRC_G1, 2'd0, 6'd0, 1'b0, 1'b0);
            6'd21: u = mk(OP_MUL, SRC_H, 2'd0, 6'd0, 1'b0, 1'b0);
            6'd22: u = mk(OP_DIVC, SRC_ACC, 2'd0, 6'd24, 1'b0, 1'b0);
            default: u = mk(OP_ADD, SRC_Y, 2'd0, 6'd0, 1'b0, pc == PC_W'(34));
          endcase
        end
      endcase
    end
    return u;
  endfunction

endpackage

FILE: src/lodi_alu.sv
// ----------------------------------------------------------------------------
// lodi_alu
// saturating fixed-point unit: registered add, sub and load, bit-serial
// multiply and bit-serial divide by a small constant
// ----------------------------------------------------------------------------
module lodi_alu (
  input  logic              clk,
  input  logic              rst,
  input  lodi_pkg::alu_req_t req,
  output lodi_pkg::alu_rsp_t rsp
);
  import lodi_pkg::*;

  alu_state_t          st, st_next;
  op_t                 op_q;
  logic [5:0]          cnt;
  logic [5:0]          cval;
  logic [WORD_W-1:0]   ma, hi, lo, nq, q;
  logic [4:0]          rem;
  logic                neg;
  logic [WORD_W:0]     sum, addv, subv;
  logic [5:0]          r2;
  logic [2*WORD_W-1:0] prod, prnd;
  logic [WORD_W:0]     fm;

  function automatic logic [WORD_W-1:0] mag(logic [WORD_W-1:0] v);
    return v[WORD_W-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [WORD_W:0] from_mag(logic n, logic [WORD_W-1:0] m, logic big);
    if (!n) begin
      if (big || m[WORD_W-1]) return {1'b1, MAXV};
      return {1'b0, m};
    end
    if (big || (m[WORD_W-1] && |m[WORD_W-2:0])) return {1'b1, MINV};
    return {1'b0, ~m + 1'b1};
  endfunction

  function automatic logic [WORD_W:0] clamp(logic [WORD_W:0] s);
    if (s[WORD_W] != s[WORD_W-1]) return {1'b1, s[WORD_W] ? MINV : MAXV};
    return {1'b0, s[WORD_W-1:0]};
  endfunction

  assign sum  = {1'b0, hi} + {1'b0, (lo[0] ? ma : '0)};
  assign addv = {req.a[WORD_W-1], req.a} + {req.b[WORD_W-1], req.b};
  assign subv = {req.b[WORD_W-1], req.b} - {req.a[WORD_W-1], req.a};
  assign r2   = {rem, nq[WORD_W-1]};
  assign prod = {hi, lo};
  assign prnd = prod + ((2*WORD_W)'(1) << (FRAC_BITS - 1));

  always_comb begin
    if (op_q == OP_MUL) begin
      fm = from_mag(neg, prnd[FRAC_BITS+WORD_W-1:FRAC_BITS],
                    |prnd[2*WORD_W-1:FRAC_BITS+WORD_W]);
    end else if (op_q == OP_MULC) begin
      fm = from_mag(neg, prod[WORD_W-1:0], |prod[2*WORD_W-1:WORD_W]);
    end else begin
      fm = {1'b0, neg ? (~q + 1'b1) : q};
    end
  end

  always_comb begin
    st_next = st;
    case (st)
      AL_IDLE: begin
        if (req.start && (req.op == OP_MUL || req.op == OP_MULC)) st_next = AL_MUL;
        else if (req.start && req.op == OP_DIVC) st_next = AL_DIV;
      end
      AL_MUL, AL_DIV: begin
        if (cnt == 6'd63) st_next = AL_FIN;
      end
      default: st_next = AL_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= AL_IDLE;
      rsp.done <= 1'b0;
    end else begin
      st       <= st_next;
      rsp.done <= 1'b0;
      case (st)
        AL_IDLE: begin
          if (req.start) begin
            op_q <= req.op;
            cnt  <= '0;
            cval <= req.c;
            case (req.op)
              OP_LD: begin
                rsp.result <= req.a;
                rsp.sat    <= 1'b0;
                rsp.done   <= 1'b1;
              end
              OP_ADD: begin
                {rsp.sat, rsp.result} <= clamp(addv);
                rsp.done <= 1'b1;
              end
              OP_SUB: begin
                {rsp.sat, rsp.result} <= clamp(subv);
                rsp.done <= 1'b1;
              end
              OP_MUL: begin
                ma  <= mag(req.a);
                lo  <= mag(req.b);
                hi  <= '0;
                neg <= req.a[WORD_W-1] ^ req.b[WORD_W-1];
              end
              OP_MULC: begin
                ma  <= mag(req.a);
                lo  <= WORD_W'(req.c);
                hi  <= '0;
                neg <= req.a[WORD_W-1];
              end
              default: begin
                nq  <= mag(req.b) + WORD_W'(req.c >> 1);
                rem <= '0;
                q   <= '0;
                neg <= req.b[WORD_W-1];
              end
            endcase
          end
        end
        AL_MUL: begin
          hi  <= sum[WORD_W:1];
          lo  <= {sum[0], lo[WORD_W-1:1]};
          cnt <= cnt + 1'b1;
        end
        AL_DIV: begin
          if (r2 >= cval) begin
            rem <= 5'(r2 - cval);
            q   <= {q[WORD_W-2:0], 1'b1};
          end else begin
            rem <= r2[4:0];
            q   <= {q[WORD_W-2:0], 1'b0};
          end
          nq  <= {nq[WORD_W-2:0], 1'b0};
          cnt <= cnt + 1'b1;
        end
        default: begin
          {rsp.sat, rsp.result} <= fm;
          rsp.done <= 1'b1;
        end
      endcase
    end
  end

endmodule

FILE: src/linear_ode_integrator_step.sv
// ----------------------------------------------------------------------------
// linear_ode_integrator_step
// one integration step of y' = k*y per non-restart beat (Euler, Heun, RK4,
// ABM4), microprogrammed over a bit-serial saturating arithmetic unit
// ----------------------------------------------------------------------------
//  channel  handshake               payload
//  cfg      cfg_valid / cfg_ready   cfg_index, cfg_data
//  in       in_valid  / in_ready    restart
//  out      out_valid / out_ready   y_value, step_index, overflow
//
// each multiply, constant multiply or constant divide runs bit-serially on the
// shared serial unit, while each add, sub or load completes directly; a step
// presents its result once the last micro-op of its method has finished.
// a restart beat goes straight to the done state and presents the initial value.
// the next beat is taken while a result waits on the output register.
// rst is synchronous and clears the configuration, state, out_valid and history.
module linear_ode_integrator_step (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        restart,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] y_value,
  output logic [31:0] step_index,
  output logic        overflow
);
  import lodi_pkg::*;

  state_t            state, state_next;
  logic [1:0]        method, mode;
  logic [WORD_W-1:0] rate, initial_value, y_now, g0, g1, g2, acc, tmp_rd, opa;
  logic [62:0]       step_size;
  logic [31:0]       step_count;
  logic [PC_W-1:0]   pc;
  uop_t              uop_q;
  uop_t              uop_f;
  logic              ovf;
  logic [WORD_W-1:0] tmp [4];
  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;
  logic              out_load;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign out_load  = (state == S_DONE) && (!out_valid || out_ready);
  assign uop_f     = get_uop(mode, pc);

  always_comb begin
    case (uop_q.src)
      SRC_K:   opa = rate;
      SRC_H:   opa = {1'b0, step_size};
      SRC_Y:   opa = y_now;
      SRC_G0:  opa = g0;
      SRC_G1:  opa = g1;
      SRC_G2:  opa = g2;
      SRC_TMP: opa = tmp_rd;
      default: opa = acc;
    endcase
    alu_req.start = (state == S_START);
    alu_req.op    = uop_q.op;
    alu_req.a     = opa;
    alu_req.b     = acc;
    alu_req.c     = uop_q.cval;
  end

  lodi_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .rsp (alu_rsp)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = restart ? S_DONE : S_FETCH;
      end
      S_FETCH: state_next = S_START;
      S_START: state_next = S_WAIT;
      S_WAIT: begin
        if (alu_rsp.done) state_next = uop_q.last ? S_DONE : S_FETCH;
      end
      default: begin
        if (out_load) state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (state == S_FETCH) begin
      uop_q  <= uop_f;
      tmp_rd <= tmp[uop_f.addr];
    end
    if (state == S_WAIT && alu_rsp.done && uop_q.st) tmp[uop_q.addr] <= alu_rsp.result;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      method        <= M_EULER;
      rate          <= '0;
      step_size     <= '0;
      initial_value <= '0;
      y_now         <= '0;
      g0            <= '0;
      g1            <= '0;
      g2            <= '0;
      step_count    <= '0;
      out_valid     <= 1'b0;
      ovf           <= 1'b0;
      pc            <= '0;
      mode          <= M_EULER;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_METHOD:  method        <= cfg_data[1:0];
          REG_RATE:    rate          <= cfg_data;
          REG_STEP:    step_size     <= cfg_data[62:0];
          REG_INITIAL: initial_value <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            ovf <= 1'b0;
            pc  <= '0;
            if (method == M_ABM && step_count < 32'd3) mode <= M_RK4;
            else                                       mode <= method;
            if (restart) begin
              y_now      <= initial_value;
              g0         <= '0;
              g1         <= '0;
              g2         <= '0;
              step_count <= '0;
            end
          end
        end
        S_WAIT: begin
          if (alu_rsp.done) begin
            acc <= alu_rsp.result;
            ovf <= ovf | alu_rsp.sat;
            pc  <= pc + 1'b1;
            if (uop_q.last) begin
              y_now <= alu_rsp.result;
              g2    <= g1;
              g1    <= g0;
              g0    <= tmp[0];
              if (step_count != 32'hffff_ffff) step_count <= step_count + 1'b1;
            end
          end
        end
        default: ;
      endcase
      if (out_load) begin
        out_valid  <= 1'b1;
        y_value    <= y_now;
        step_index <= step_count;
        overflow   <= ovf;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    alu_rsp.done |-> state == S_WAIT)
    else $error("arithmetic unit finished outside wait state");

  a_restart_fast: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && restart) |=> state == S_DONE)
    else $error("restart beat did not go straight to result");

  a_out_loaded: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid && state == S_IDLE)
    else $error("result not presented after step end");

endmodule
